/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the waypoint follower.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define WSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked outside reset
`define WSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define WSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/wss_pkg.sv */
// Constants, register indexes and helper functions of the waypoint follower.
// No dependencies.
package wss_pkg;

    // waypoint corners
    localparam int NUM_WAYPOINTS = 4;
    localparam int WP_W          = $clog2(NUM_WAYPOINTS);
    localparam logic [WP_W-1:0] WP_MIN_MIN = WP_W'(0);
    localparam logic [WP_W-1:0] WP_MIN_MAX = WP_W'(1);
    localparam logic [WP_W-1:0] WP_MAX_MAX = WP_W'(2);
    localparam logic [WP_W-1:0] WP_MAX_MIN = WP_W'(3);

    // configuration register indexes
    localparam logic [2:0] CFG_FOLLOW_EN = 3'd0;
    localparam logic [2:0] CFG_SPEED     = 3'd1;
    localparam logic [2:0] CFG_AREA_W    = 3'd2;
    localparam logic [2:0] CFG_AREA_H    = 3'd3;
    localparam logic [2:0] CFG_MARGIN    = 3'd4;
    localparam logic [2:0] CFG_RADIUS    = 3'd5;

    // register reset values
    localparam logic        RST_FOLLOW_EN = 1'b1;
    localparam logic [15:0] RST_SPEED     = 16'd200;
    localparam logic [13:0] RST_AREA_W    = 14'd1024;
    localparam logic [13:0] RST_AREA_H    = 14'd768;
    localparam logic [9:0]  RST_MARGIN    = 10'd25;
    localparam logic [15:0] RST_RADIUS    = 16'd512;

    // position reset 25.0 in Q16.8, saturation limits
    localparam logic signed [23:0] POS_RESET = 24'sd6400;
    localparam logic signed [27:0] POS_MAX   = 28'sd8388607;
    localparam logic signed [27:0] POS_MIN   = -28'sd8388608;

    // heading: +-180 deg in Q9.7, quarter turn in deg * 2^16
    localparam logic [16:0]        HEAD_LIM  = 17'd23040;
    localparam logic signed [25:0] Z_QUARTER = 26'sd5898240;

    // atan(2^-i) in degrees * 2^16, rounded
    function automatic logic [21:0] atan_deg16(input logic [3:0] idx);
        logic [21:0] v;
        case (idx)
            4'd0:    v = 22'd2949120;
            4'd1:    v = 22'd1740967;
            4'd2:    v = 22'd919879;
            4'd3:    v = 22'd466945;
            4'd4:    v = 22'd234379;
            4'd5:    v = 22'd117304;
            4'd6:    v = 22'd58666;
            4'd7:    v = 22'd29335;
            4'd8:    v = 22'd14668;
            4'd9:    v = 22'd7334;
            4'd10:   v = 22'd3667;
            4'd11:   v = 22'd1833;
            4'd12:   v = 22'd917;
            4'd13:   v = 22'd458;
            4'd14:   v = 22'd229;
            4'd15:   v = 22'd115;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // clamp a widened coordinate to signed 24 bits
    function automatic logic [23:0] sat24(input logic signed [27:0] v);
        logic [23:0] r;
        if (v > POS_MAX) begin
            r = 24'h7FFFFF;
        end else if (v < POS_MIN) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/waypoint_seek_steering.sv */
// Waypoint seek steering: top level, sequencer and shared datapath.
// Depends on wss_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one tick with its elapsed time
//   i_tick_time (Q0.16 s). Output channel (o_valid / i_ready) returns one
//   result per tick: position (Q16.8), heading (Q9.7 deg) and waypoint index.
//   Configuration is a write port (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata);
//   the user must write it only while no tick is in flight, which the
//   block itself does not enforce. With following on and a nonzero target
//   vector a tick runs the full sequence; a zero vector skips the root,
//   CORDIC, divisions and move; with following off it goes straight to the
//   result. The block holds one tick at a time: o_ready returns in the cycle
//   after the result transfer. One shared subtract/compare unit does a
//   29-step square root and two 26-step divisions, one shared multiplier
//   runs eight passes, and a 16-step CORDIC runs beside the root.
//   Reset (synchronous, active low) puts the position at (25.0, 25.0),
//   heading and waypoint at zero and the registers at their defaults.
//   If the receiver stalls, the result holds and no new tick is taken.
module waypoint_seek_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_tick_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_pos_x,
    output logic [23:0] o_pos_y,
    output logic [15:0] o_heading,
    output logic [1:0]  o_waypoint,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_MSTEP, S_MDX, S_MDY, S_SQINIT, S_SQRT, S_MNX,
        S_DINIT, S_DIV, S_MNY, S_UPD, S_NDIFF, S_MNDX, S_MNDY, S_MR,
        S_ARR, S_OUT
    } t_state;

    // configuration registers
    logic        r_follow_en;
    logic [15:0] r_speed;
    logic [13:0] r_area_w;
    logic [13:0] r_area_h;
    logic [9:0]  r_margin;
    logic [15:0] r_radius;

    // control and architectural state
    t_state                  r_state;
    logic [23:0]             r_pos_x;
    logic [23:0]             r_pos_y;
    logic [15:0]             r_heading;
    logic [wss_pkg::WP_W-1:0] r_wp;
    logic [4:0]              r_cnt;
    logic [4:0]              r_ci;
    logic                    r_axis;

    // datapath registers
    logic [15:0]        r_tt;
    logic [24:0]        r_dx;
    logic [24:0]        r_dy;
    logic [31:0]        r_step;
    logic [48:0]        r_sq;
    logic [55:0]        r_prod;
    logic [33:0]        r_rem;
    logic [57:0]        r_acc;
    logic [28:0]        r_root;
    logic [25:0]        r_qx;
    logic signed [35:0] r_cx;
    logic signed [35:0] r_cy;
    logic signed [25:0] r_cz;

    // ---------------------------------------------------------------
    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow_en <= wss_pkg::RST_FOLLOW_EN;
            r_speed     <= wss_pkg::RST_SPEED;
            r_area_w    <= wss_pkg::RST_AREA_W;
            r_area_h    <= wss_pkg::RST_AREA_H;
            r_margin    <= wss_pkg::RST_MARGIN;
            r_radius    <= wss_pkg::RST_RADIUS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                wss_pkg::CFG_FOLLOW_EN: r_follow_en <= i_cfg_wdata[0];
                wss_pkg::CFG_SPEED:     r_speed     <= i_cfg_wdata;
                wss_pkg::CFG_AREA_W:    r_area_w    <= i_cfg_wdata[13:0];
                wss_pkg::CFG_AREA_H:    r_area_h    <= i_cfg_wdata[13:0];
                wss_pkg::CFG_MARGIN:    r_margin    <= i_cfg_wdata[9:0];
                wss_pkg::CFG_RADIUS:    r_radius    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // target corner and difference vector (Q16.8, 25-bit signed)
    logic        tgt_lo_x;
    logic        tgt_lo_y;
    logic [15:0] tgt_x;
    logic [15:0] tgt_y;
    logic [24:0] n_dx;
    logic [24:0] n_dy;
    logic [23:0] mag_dx;
    logic [23:0] mag_dy;
    logic [24:0] neg_dx;
    logic [24:0] neg_dy;

    always_comb begin
        tgt_lo_x = (r_wp == wss_pkg::WP_MIN_MIN) || (r_wp == wss_pkg::WP_MIN_MAX);
        tgt_lo_y = (r_wp == wss_pkg::WP_MIN_MIN) || (r_wp == wss_pkg::WP_MAX_MIN);
        tgt_x = tgt_lo_x ? {6'b0, r_margin} : ({2'b0, r_area_w} - {6'b0, r_margin});
        tgt_y = tgt_lo_y ? {6'b0, r_margin} : ({2'b0, r_area_h} - {6'b0, r_margin});
        n_dx = {tgt_x[15], tgt_x, 8'b0} - {r_pos_x[23], r_pos_x};
        n_dy = {tgt_y[15], tgt_y, 8'b0} - {r_pos_y[23], r_pos_y};
        neg_dx = -r_dx;
        neg_dy = -r_dy;
        mag_dx = r_dx[24] ? neg_dx[23:0] : r_dx[23:0];
        mag_dy = r_dy[24] ? neg_dy[23:0] : r_dy[23:0];
    end

    // ---------------------------------------------------------------
    // shared multiplier, product registered
    logic [23:0] mul_a;
    logic [31:0] mul_b;

    always_comb begin
        case (r_state)
            S_MSTEP: begin
                mul_a = {8'b0, r_speed};
                mul_b = {16'b0, r_tt};
            end
            S_MDX, S_MNDX: begin
                mul_a = mag_dx;
                mul_b = {8'b0, mag_dx};
            end
            S_MDY, S_MNDY: begin
                mul_a = mag_dy;
                mul_b = {8'b0, mag_dy};
            end
            S_MNX: begin
                mul_a = mag_dx;
                mul_b = r_step;
            end
            S_MNY: begin
                mul_a = mag_dy;
                mul_b = r_step;
            end
            S_MR: begin
                mul_a = {8'b0, r_radius};
                mul_b = {16'b0, r_radius};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 56'(mul_a) * 56'(mul_b);
    end

    // ---------------------------------------------------------------
    // shared subtract/compare unit: root digit or quotient bit
    logic [32:0] den;
    logic [33:0] sub_a;
    logic [33:0] sub_b;
    logic [33:0] sub_diff;
    logic        sub_ge;

    assign den = {r_root, 4'b0};

    always_comb begin
        if (r_state == S_SQRT) begin
            sub_a = {r_rem[31:0], r_acc[57:56]};
            sub_b = {3'b0, r_root, 2'b01};
        end else begin
            sub_a = {r_rem[32:0], r_acc[25]};
            sub_b = {1'b0, den};
        end
        sub_ge   = (sub_a >= sub_b);
        sub_diff = sub_a - sub_b;
    end

    // division setup: numerator plus half divisor for round-to-nearest
    logic [56:0] div_num;
    assign div_num = {1'b0, r_prod} + {25'b0, r_root, 3'b0};

    // squared length; times 256 it is the radicand
    logic [48:0] sq_sum;
    assign sq_sum = r_sq + {1'b0, r_prod[47:0]};

    // ---------------------------------------------------------------
    // CORDIC vectoring step and pre-rotation
    logic signed [35:0] c_xs;
    logic signed [35:0] c_ys;
    logic signed [25:0] c_atan;
    logic signed [35:0] n_cx;
    logic signed [35:0] n_cy;
    logic signed [25:0] n_cz;
    logic signed [35:0] ci_x;
    logic signed [35:0] ci_y;
    logic signed [35:0] p_cx;
    logic signed [35:0] p_cy;
    logic signed [25:0] p_cz;

    always_comb begin
        c_xs   = r_cx >>> r_ci[3:0];
        c_ys   = r_cy >>> r_ci[3:0];
        c_atan = signed'({4'b0, wss_pkg::atan_deg16(r_ci[3:0])});
        if (!r_cy[35]) begin
            n_cx = r_cx + c_ys;
            n_cy = r_cy - c_xs;
            n_cz = r_cz + c_atan;
        end else begin
            n_cx = r_cx - c_ys;
            n_cy = r_cy + c_xs;
            n_cz = r_cz - c_atan;
        end
        ci_x = signed'({{3{r_dx[24]}}, r_dx, 8'b0});
        ci_y = signed'({{3{r_dy[24]}}, r_dy, 8'b0});
        // left half-plane: rotate by a quarter turn first
        if (!r_dx[24]) begin
            p_cx = ci_x;
            p_cy = ci_y;
            p_cz = '0;
        end else if (!r_dy[24]) begin
            p_cx = ci_y;
            p_cy = -ci_x;
            p_cz = wss_pkg::Z_QUARTER;
        end else begin
            p_cx = -ci_y;
            p_cy = ci_x;
            p_cz = -wss_pkg::Z_QUARTER;
        end
    end

    // heading: round half away from zero to Q9.7, clamp to +-180 deg
    logic [25:0] z_abs;
    logic [25:0] z_rnd;
    logic [16:0] z_mag;
    logic [15:0] z_lim;
    logic [15:0] n_heading;

    always_comb begin
        z_abs     = r_cz[25] ? 26'(-r_cz) : 26'(r_cz);
        z_rnd     = z_abs + 26'd256;
        z_mag     = z_rnd[25:9];
        z_lim     = (z_mag > wss_pkg::HEAD_LIM) ? wss_pkg::HEAD_LIM[15:0] : z_mag[15:0];
        n_heading = r_cz[25] ? -z_lim : z_lim;
    end

    // position update with saturation
    logic signed [27:0] pos_xw;
    logic signed [27:0] pos_yw;
    logic signed [27:0] qx_w;
    logic signed [27:0] qy_w;
    logic [23:0]        n_pos_x;
    logic [23:0]        n_pos_y;

    always_comb begin
        pos_xw  = signed'({{4{r_pos_x[23]}}, r_pos_x});
        pos_yw  = signed'({{4{r_pos_y[23]}}, r_pos_y});
        qx_w    = signed'({2'b0, r_qx});
        qy_w    = signed'({2'b0, r_acc[25:0]});
        n_pos_x = wss_pkg::sat24(r_dx[24] ? (pos_xw - qx_w) : (pos_xw + qx_w));
        n_pos_y = wss_pkg::sat24(r_dy[24] ? (pos_yw - qy_w) : (pos_yw + qy_w));
    end

    // ---------------------------------------------------------------
    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos_x   <= wss_pkg::POS_RESET;
            r_pos_y   <= wss_pkg::POS_RESET;
            r_heading <= '0;
            r_wp      <= '0;
            r_cnt     <= '0;
            r_ci      <= '0;
            r_axis    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= r_follow_en ? S_DIFF : S_OUT;
                    end
                end
                S_DIFF: begin
                    r_state <= S_MSTEP;
                end
                S_MSTEP: begin
                    // zero vector: no move, heading cleared
                    if ((r_dx == '0) && (r_dy == '0)) begin
                        r_heading <= '0;
                        r_state   <= S_NDIFF;
                    end else begin
                        r_state <= S_MDX;
                    end
                end
                S_MDX: begin
                    r_state <= S_MDY;
                end
                S_MDY: begin
                    r_state <= S_SQINIT;
                end
                S_SQINIT: begin
                    r_cnt   <= 5'd28;
                    r_ci    <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (!r_ci[4]) begin
                        r_ci <= r_ci + 5'd1;
                    end
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_axis  <= 1'b0;
                        r_state <= S_MNX;
                    end
                end
                S_MNX: begin
                    r_heading <= n_heading;
                    r_state   <= S_DINIT;
                end
                S_DINIT: begin
                    r_cnt   <= 5'd25;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= r_axis ? S_UPD : S_MNY;
                    end
                end
                S_MNY: begin
                    r_axis  <= 1'b1;
                    r_state <= S_DINIT;
                end
                S_UPD: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_state <= S_NDIFF;
                end
                S_NDIFF: begin
                    r_state <= S_MNDX;
                end
                S_MNDX: begin
                    r_state <= S_MNDY;
                end
                S_MNDY: begin
                    r_state <= S_MR;
                end
                S_MR: begin
                    r_state <= S_ARR;
                end
                S_ARR: begin
                    if (r_sq < {17'b0, r_prod[31:0]}) begin
                        r_wp <= r_wp + wss_pkg::WP_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tt <= i_tick_time;
            end
            S_DIFF, S_NDIFF: begin
                r_dx <= n_dx;
                r_dy <= n_dy;
            end
            S_MDX: begin
                r_step <= r_prod[31:0];
            end
            S_MDY, S_MNDY: begin
                r_sq <= {1'b0, r_prod[47:0]};
            end
            S_MR: begin
                r_sq <= sq_sum;
            end
            S_SQINIT: begin
                r_acc  <= {1'b0, sq_sum, 8'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_cx   <= p_cx;
                r_cy   <= p_cy;
                r_cz   <= p_cz;
            end
            S_SQRT: begin
                r_rem  <= sub_ge ? sub_diff : sub_a;
                r_root <= {r_root[27:0], sub_ge};
                r_acc  <= {r_acc[55:0], 2'b00};
                if (!r_ci[4]) begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                end
            end
            S_DINIT: begin
                r_rem <= {3'b0, div_num[56:26]};
                r_acc <= {32'b0, div_num[25:0]};
            end
            S_DIV: begin
                r_rem <= sub_ge ? sub_diff : sub_a;
                r_acc <= {r_acc[56:0], sub_ge};
            end
            S_MNY: begin
                r_qx <= r_acc[25:0];
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // ports
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_pos_x    = r_pos_x;
    assign o_pos_y    = r_pos_y;
    assign o_heading  = r_heading;
    assign o_waypoint = r_wp;

    // ---------------------------------------------------------------
    // assertions
    `include "assert_macros.svh"

    `WSS_ASSERT_IMPL(a_ready_valid_excl, i_clk, i_rst_n, o_ready, !o_valid)
    `WSS_ASSERT_IMPL(a_div_rem_bound, i_clk, i_rst_n, (r_state == S_DIV), (r_rem < {1'b0, den}))
    `WSS_ASSERT_IMPL(a_wp_change_at_arrival, i_clk, i_rst_n, !$stable(r_wp), ($past(r_state) == S_ARR) || !$past(i_rst_n))
    `WSS_ASSERT_NEXT(a_zero_vec_heading, i_clk, i_rst_n, (r_state == S_MSTEP) && (r_dx == '0) && (r_dy == '0), (r_heading == '0) && (r_state == S_NDIFF))

endmodule

/* bench/waypoint_seek_steering_tb.sv */
// Self-checking bench for waypoint_seek_steering: directed ticks, then randomized phases.
// A fixed-point seek model predicts each result. Depends on wss_pkg and the top-level RTL.
module waypoint_seek_steering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wss_pkg::*;

    // register image as written through the config port
    typedef struct packed {
        logic        follow;
        logic [15:0] speed;
        logic [13:0] width;
        logic [13:0] height;
        logic [9:0]  margin;
        logic [15:0] radius;
    } settings_t;

    // one result transfer
    typedef struct packed {
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [15:0] heading;
        logic [1:0]  wp;
    } fix_t;

    localparam settings_t DEFAULT_CFG = '{follow: RST_FOLLOW_EN, speed: RST_SPEED,
                                          width: RST_AREA_W, height: RST_AREA_H,
                                          margin: RST_MARGIN, radius: RST_RADIUS};
    localparam longint Q8_MAX       = 8388607;
    localparam longint Q8_MIN       = -8388608;
    localparam longint HEAD_CLAMP   = 23040;
    localparam int     RANDOM_SETS  = 14;
    localparam int     TICKS_PER_SET = 134;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [15:0] i_tick_time = '0;
    logic        i_ready     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_addr  = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_ready;
    logic        o_valid;
    logic [23:0] o_pos_x;
    logic [23:0] o_pos_y;
    logic [15:0] o_heading;
    logic [1:0]  o_waypoint;

    // predictor state and register copy
    settings_t          cur_cfg  = DEFAULT_CFG;
    logic signed [23:0] st_x     = POS_RESET;
    logic signed [23:0] st_y     = POS_RESET;
    logic signed [15:0] st_head  = '0;
    logic [1:0]         st_wp    = '0;
    fix_t               pending_fixes [$];

    // atan(2^-i) in degrees scaled by 2^16
    longint atan_step_deg [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                   58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                   229, 115};

    bit send_back_to_back   = 1'b0;
    bit accept_every_cycle  = 1'b0;
    int err_count    = 0;
    int n_ticks      = 0;
    int n_results    = 0;
    int n_settings   = 0;
    int n_arrivals   = 0;
    int n_zero_vec   = 0;
    int n_saturated  = 0;
    int n_held       = 0;

    waypoint_seek_steering u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_tick_time (i_tick_time),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_heading   (o_heading),
        .o_waypoint  (o_waypoint),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- seek model ----------------

    // bitwise floor square root
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem, root, probe;
        rem   = v;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // CORDIC vectoring, result in Q9.7 degrees
    function automatic logic signed [15:0] cordic_deg(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys;
        int i;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        // left half plane: quarter turn first
        if (dx < 0) begin
            if (dy >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_step_deg[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_step_deg[i];
            end
        end
        // round half away from zero, then clamp to +-180
        if (z >= 0) z = (z + 256) >>> 9;
        else z = -((-z + 256) >>> 9);
        if (z > HEAD_CLAMP) z = HEAD_CLAMP;
        if (z < -HEAD_CLAMP) z = -HEAD_CLAMP;
        return 16'(z);
    endfunction

    function automatic logic signed [23:0] clamp_q8(input longint v);
        if (v > Q8_MAX) begin
            n_saturated++;
            return 24'sh7FFFFF;
        end
        if (v < Q8_MIN) begin
            n_saturated++;
            return 24'sh800000;
        end
        return 24'(v);
    endfunction

    // signed share of the step along one axis, rounded half up
    function automatic longint axis_move(input longint d, input longint unsigned step,
                                         input longint unsigned den);
        longint unsigned mag, q;
        mag = (d < 0) ? longint'(-d) : d;
        q   = (mag * step + den / 2) / den;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // advance the model by one tick and return the result it should produce
    function automatic fix_t steer_predict(input logic [15:0] tt);
        longint tx, ty, dx, dy, m;
        longint unsigned step, sq, den, d2, r2;
        fix_t r;
        if (cur_cfg.follow) begin
            m  = longint'(cur_cfg.margin);
            tx = (st_wp == WP_MIN_MIN || st_wp == WP_MIN_MAX) ? m : longint'(cur_cfg.width) - m;
            ty = (st_wp == WP_MIN_MIN || st_wp == WP_MAX_MIN) ? m : longint'(cur_cfg.height) - m;
            tx = tx * 256;
            ty = ty * 256;
            dx = tx - longint'(st_x);
            dy = ty - longint'(st_y);
            if (dx != 0 || dy != 0) begin
                step    = longint'(cur_cfg.speed) * longint'(tt);
                sq      = dx * dx + dy * dy;
                den     = int_sqrt(sq * 256) * 16;
                st_head = cordic_deg(dx, dy);
                st_x    = clamp_q8(longint'(st_x) + axis_move(dx, step, den));
                st_y    = clamp_q8(longint'(st_y) + axis_move(dy, step, den));
            end else begin
                st_head = '0;
                n_zero_vec++;
            end
            // arrival test on the distance left
            dx = tx - longint'(st_x);
            dy = ty - longint'(st_y);
            d2 = dx * dx + dy * dy;
            r2 = longint'(cur_cfg.radius) * longint'(cur_cfg.radius);
            if (d2 < r2) begin
                st_wp = st_wp + 2'd1;
                n_arrivals++;
            end
        end else begin
            n_held++;
        end
        r.pos_x   = st_x;
        r.pos_y   = st_y;
        r.heading = st_head;
        r.wp      = st_wp;
        return r;
    endfunction

    // ---------------- drivers ----------------

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40) $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    // one tick transfer; valid stays up afterwards so the next tick can follow at once
    task automatic send_tick(input logic [15:0] tt);
        int gap;
        gap = send_back_to_back ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_tick_time <= tt;
        do @(posedge i_clk); while (!o_ready);
        pending_fixes.push_back(steer_predict(tt));
        n_ticks++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write every register once the block is idle
    task automatic load_settings(input settings_t s);
        logic [2:0] idx;
        int k;
        wait_drained();
        for (k = 0; k < 6; k++) begin
            idx = 3'(k);
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= idx;
            case (idx)
                CFG_FOLLOW_EN: i_cfg_wdata <= 16'(s.follow);
                CFG_SPEED:     i_cfg_wdata <= s.speed;
                CFG_AREA_W:    i_cfg_wdata <= 16'(s.width);
                CFG_AREA_H:    i_cfg_wdata <= 16'(s.height);
                CFG_MARGIN:    i_cfg_wdata <= 16'(s.margin);
                CFG_RADIUS:    i_cfg_wdata <= s.radius;
                default:       i_cfg_wdata <= '0;
            endcase
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cur_cfg = s;
        n_settings++;
    endtask

    // result side: random stalls, some only after valid shows up
    initial begin : result_sink
        int stall;
        bit late;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = accept_every_cycle ? 0 : $urandom_range(0, 16);
            late  = !accept_every_cycle && ($urandom_range(0, 1) == 1);
            if (late || stall > 0) i_ready <= 1'b0;
            if (late) do @(posedge i_clk); while (!o_valid);
            repeat (stall) @(posedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        fix_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_fixes.size() == 0) begin
                report_mismatch("result transfer with no tick outstanding");
            end else begin
                want = pending_fixes.pop_front();
                n_results++;
                if (o_pos_x !== want.pos_x)
                    report_mismatch($sformatf("pos_x: expected %0d, got %0d",
                                              $signed(want.pos_x), $signed(o_pos_x)));
                if (o_pos_y !== want.pos_y)
                    report_mismatch($sformatf("pos_y: expected %0d, got %0d",
                                              $signed(want.pos_y), $signed(o_pos_y)));
                if (o_heading !== want.heading)
                    report_mismatch($sformatf("heading: expected %0d, got %0d",
                                              $signed(want.heading), $signed(o_heading)));
                if (o_waypoint !== want.wp)
                    report_mismatch($sformatf("waypoint: expected %0d, got %0d",
                                              want.wp, o_waypoint));
            end
        end
    end

    // ---------------- tests ----------------

    // first tick out of reset: target equals position, arrival at once
    task automatic test_reset_state();
        send_tick(16'hFFFF);
    endtask

    // hold still with speed 0, then put the target right on the position
    task automatic test_zero_vector();
        settings_t s;
        s        = DEFAULT_CFG;
        s.speed  = '0;
        s.radius = '0;
        s.height = 14'd60;
        load_settings(s);
        send_tick(16'hFFFF);
        s.height = 14'd50;
        load_settings(s);
        send_tick(16'h8000);
    endtask

    task automatic test_default_motion();
        load_settings(DEFAULT_CFG);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        send_tick(16'h0001);
        send_tick(16'h8000);
        send_tick(16'h7FFF);
    endtask

    task automatic test_hold();
        settings_t s;
        s        = DEFAULT_CFG;
        s.follow = 1'b0;
        load_settings(s);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
    endtask

    // full speed, full ticks: overshoot far past the corners and hit the rails
    task automatic test_saturation();
        settings_t s;
        s        = DEFAULT_CFG;
        s.speed  = 16'hFFFF;
        s.width  = 14'd8192;
        s.height = 14'd8192;
        s.margin = '0;
        s.radius = '0;
        load_settings(s);
        repeat (4) send_tick(16'hFFFF);
        s.margin = 10'd1023;
        s.radius = 16'hFFFF;
        load_settings(s);
        send_tick(16'hFFFF);
        send_tick(16'h5555);
    endtask

    // degenerate fields put corners at negative coordinates
    task automatic test_small_field();
        settings_t s;
        s        = DEFAULT_CFG;
        s.width  = '0;
        s.height = 14'd1;
        s.margin = 10'd1023;
        s.speed  = 16'd1000;
        s.radius = 16'hFFFF;
        load_settings(s);
        repeat (3) send_tick(16'($urandom()));
        s.width  = 14'd1;
        s.height = '0;
        s.margin = '0;
        load_settings(s);
        repeat (3) send_tick(16'($urandom()));
    endtask

    // random register sets, each followed by a run of random ticks
    task automatic test_random();
        settings_t s;
        int set_no, k;
        for (set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            s.follow = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 3))
                0:       s.speed = 16'($urandom_range(0, 400));
                1:       s.speed = 16'($urandom_range(400, 4000));
                2:       s.speed = 16'($urandom());
                default: s.speed = 16'($urandom_range(100, 300));
            endcase
            s.width  = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(1, 8192))
                                                   : 14'($urandom_range(64, 2048));
            s.height = ($urandom_range(0, 4) == 0) ? 14'($urandom_range(1, 8192))
                                                   : 14'($urandom_range(64, 2048));
            s.margin = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                   : 10'($urandom_range(0, 100));
            // mostly a generous radius so the corners actually get reached
            s.radius = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(1024, 65535));
            load_settings(s);
            send_back_to_back  = ($urandom_range(0, 3) == 0);
            accept_every_cycle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < TICKS_PER_SET; k++) begin
                if ($urandom_range(0, 49) == 0) wait_drained();
                if ($urandom_range(0, 2) == 0) send_tick(16'($urandom_range(0, 4095)));
                else send_tick(16'($urandom()));
            end
        end
        send_back_to_back  = 1'b0;
        accept_every_cycle = 1'b0;
    endtask

    initial begin : main_flow
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_zero_vector();
        test_default_motion();
        test_hold();
        test_saturation();
        test_small_field();
        test_random();
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d ticks under %0d register sets: %0d arrivals, %0d zero vectors,",
                 n_ticks, n_settings, n_arrivals, n_zero_vec);
        $display("%0d saturated coordinates, %0d held ticks; %0d results checked, %0d errors",
                 n_saturated, n_held, n_results, err_count);
        if (err_count == 0) begin
            $display("waypoint_seek_steering_tb: done, clean");
        end else begin
            $display("waypoint_seek_steering_tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #10_000_000;
        $display("timeout: %0d ticks sent, %0d results outstanding",
                 n_ticks, pending_fixes.size());
        $display("waypoint_seek_steering_tb: done, errors");
        $finish;
    end

endmodule
